[sv/sjeuc_pkg.sv]
// Shared types and byte constants for the EUC-JP / Shift-JIS stream converter.
// Used by sjeuc_convert, sjeuc_out_buf and sjis_euc_stream_converter; no dependencies.
package sjeuc_pkg;

	localparam logic [7:0] SS2_BYTE   = 8'h8e;
	localparam logic [7:0] NUL_BYTE   = 8'h00;
	localparam logic [7:0] JIS_BASE   = 8'h21;
	localparam logic [7:0] SJ_LEAD_LO = 8'h81;
	localparam logic [7:0] SJ_LEAD_HI = 8'h9f;
	localparam logic [7:0] SJ_SHIFT   = 8'h40;
	localparam logic [7:0] CELL_BREAK = 8'h5f;
	localparam logic [7:0] EVEN_OFS   = 8'h7e;
	localparam logic [7:0] ODD_OFS    = 8'h1f;
	localparam logic [7:0] SJ_HI_BASE = 8'hc1;
	localparam logic [7:0] SJ_BAD_LD  = 8'hf0;
	localparam logic [7:0] KANA_HI    = 8'hdf;
	localparam logic [7:0] ROW_EVEN   = 8'h22;
	localparam logic [7:0] KANA_LO    = 8'ha1;
	localparam logic [7:0] EUC_LD_HI  = 8'hfe;
	localparam logic [7:0] SJ_LD2_LO  = 8'he0;
	localparam logic [7:0] SJ_LD2_HI  = 8'hfc;

	// Byte held between two requests.
	typedef struct packed {
		logic       pending;
		logic [7:0] lead;
		logic       kana;
	} state_t;

	// Zero, one or two output bytes produced by one request.
	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       end0;
		logic       end1;
	} result_t;

endpackage

[sv/sjeuc_convert.sv]
// Combinational conversion of one byte against the held lead state.
// Depends on sjeuc_pkg for state_t, result_t and the byte constants.
module sjeuc_convert (
	input  logic             direction,
	input  logic [7:0]       in_byte,
	input  sjeuc_pkg::state_t state_cur,
	output sjeuc_pkg::state_t state_nxt,
	output sjeuc_pkg::result_t res
);
	import sjeuc_pkg::*;

	logic [7:0] hi, lo, nh, nl;
	logic [7:0] s1b, s2b, b1r, r1, r2;
	logic       sj_bad;

	// JIS row/cell (from EUC) to a Shift-JIS pair.
	always_comb begin
		hi = {1'b0, state_cur.lead[6:0]};
		lo = {1'b0, in_byte[6:0]};
		nh = ((hi - JIS_BASE) >> 1) + SJ_LEAD_LO;
		if (nh > SJ_LEAD_HI) begin
			nh = nh + SJ_SHIFT;
		end
		if (hi[0]) begin
			nl = lo + ODD_OFS + ((lo > CELL_BREAK) ? 8'd1 : 8'd0);
		end else begin
			nl = lo + EVEN_OFS;
		end
	end

	// Shift-JIS pair to EUC; an invalid pair becomes the ideographic space.
	always_comb begin
		s1b = state_cur.lead;
		s2b = in_byte;
		sj_bad = (s1b < SJ_LEAD_LO) || (s1b >= SJ_BAD_LD) ||
			(s1b >= 8'ha0 && s1b <= KANA_HI) ||
			(s2b < SJ_SHIFT) || (s2b >= EUC_LD_HI) || (s2b == 8'h7f);
		if (sj_bad) begin
			s1b = SJ_LEAD_LO;
			s2b = SJ_SHIFT;
		end
		b1r = s1b - ((s1b >= 8'ha0) ? SJ_HI_BASE : SJ_LEAD_LO);
		if (s2b >= SJ_LEAD_HI) begin
			r1 = {b1r[6:0], 1'b0} + ROW_EVEN;
			r2 = s2b - EVEN_OFS;
		end else begin
			r1 = {b1r[6:0], 1'b0} + JIS_BASE;
			r2 = s2b - ((s2b <= EVEN_OFS) ? ODD_OFS : 8'h20);
		end
		r1 = r1 | 8'h80;
		r2 = r2 | 8'h80;
	end

	always_comb begin
		state_nxt = '0;
		res = '0;
		if (state_cur.pending) begin
			if (in_byte == NUL_BYTE) begin
				res.cnt = 2'd2;
				res.byte0 = state_cur.lead;
				res.byte1 = NUL_BYTE;
				res.end1 = 1'b1;
			end else if (state_cur.kana) begin
				res.cnt = 2'd1;
				res.byte0 = in_byte;
			end else if (!direction) begin
				res.cnt = 2'd2;
				res.byte0 = nh;
				res.byte1 = nl;
			end else begin
				res.cnt = 2'd2;
				res.byte0 = r1;
				res.byte1 = r2;
			end
		end else if (in_byte == NUL_BYTE) begin
			res.cnt = 2'd1;
			res.byte0 = NUL_BYTE;
			res.end0 = 1'b1;
		end else if (!direction) begin
			if (in_byte == SS2_BYTE || (in_byte >= KANA_LO && in_byte <= EUC_LD_HI)) begin
				state_nxt.pending = 1'b1;
				state_nxt.lead = in_byte;
				state_nxt.kana = (in_byte == SS2_BYTE);
			end else begin
				res.cnt = 2'd1;
				res.byte0 = in_byte;
			end
		end else begin
			if (in_byte >= KANA_LO && in_byte <= KANA_HI) begin
				res.cnt = 2'd2;
				res.byte0 = SS2_BYTE;
				res.byte1 = in_byte;
			end else if ((in_byte >= SJ_LEAD_LO && in_byte <= SJ_LEAD_HI) ||
				(in_byte >= SJ_LD2_LO && in_byte <= SJ_LD2_HI)) begin
				state_nxt.pending = 1'b1;
				state_nxt.lead = in_byte;
			end else begin
				res.cnt = 2'd1;
				res.byte0 = in_byte;
			end
		end
	end

endmodule

[sv/sjeuc_out_buf.sv]
// Result register holding the one or two bytes of a request and sending them in order.
// Depends on sjeuc_pkg for result_t.
module sjeuc_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_valid,
	input  sjeuc_pkg::result_t load_res,
	output logic               room,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               run_last,
	output logic               string_end
);
	import sjeuc_pkg::*;

	logic       valid_q;
	logic       ptr_q;
	logic       two_q;
	logic [7:0] byte0_q, byte1_q;
	logic       end0_q, end1_q;
	logic       last_sel;

	assign last_sel   = ptr_q || !two_q;
	assign room       = !valid_q || (!out_stall && last_sel);
	assign out_valid  = valid_q;
	assign out_byte   = ptr_q ? byte1_q : byte0_q;
	assign run_last   = last_sel;
	assign string_end = ptr_q ? end1_q : end0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ptr_q <= 1'b0;
			two_q <= 1'b0;
		end else if (room && load_valid && load_res.cnt != 2'd0) begin
			valid_q <= 1'b1;
			ptr_q <= 1'b0;
			two_q <= (load_res.cnt == 2'd2);
		end else if (valid_q && !out_stall) begin
			if (last_sel) begin
				valid_q <= 1'b0;
			end else begin
				ptr_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (room && load_valid) begin
			byte0_q <= load_res.byte0;
			byte1_q <= load_res.byte1;
			end0_q <= load_res.end0;
			end1_q <= load_res.end1;
		end
	end

endmodule

[sv/sjis_euc_stream_converter.sv]
// Top level of the EUC-JP / Shift-JIS byte stream converter.
// Instantiates sjeuc_convert and sjeuc_out_buf; depends on sjeuc_pkg.
//
// Usage:
// Input bytes arrive on in_valid / in_stall / data_byte; a request is taken at a
// clock edge with in_valid high and in_stall low. Converted bytes leave on
// out_valid / out_stall with out_byte, run_last and string_end, taken at an edge
// with out_valid high and out_stall low.
// A request first lands in an input register; the conversion logic then writes
// its results into the result register, from which its output bytes are taken.
// A lead byte or SS2 prefix gives no output and is held for the next request.
// Throughput is one request per cycle while the receiver does not stall and each
// makes at most one byte; a two-byte request holds the result register until
// both bytes are taken, as the single output channel sends one byte per cycle.
// The input register takes a new request while a result waits to be taken.
// When the receiver stalls, the result holds, then the input register fills and
// in_stall rises.
// Writing direction selects the way (0 EUC-JP to Shift-JIS, 1 the reverse)
// and drops any held byte. Reset sets direction to 0 and clears all held state.
module sjis_euc_stream_converter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       direction_we,
	input  logic       direction,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       string_end
);
	import sjeuc_pkg::*;

	logic       direction_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	state_t     state_q;
	state_t     state_nxt;
	result_t    res;
	logic       room;

	assign in_stall = valid_s1 && !room;

	sjeuc_convert u_convert (
		.direction (direction_q),
		.in_byte   (byte_s1),
		.state_cur (state_q),
		.state_nxt (state_nxt),
		.res       (res)
	);

	sjeuc_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_res   (res),
		.room       (room),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.string_end (string_end)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
			valid_s1 <= 1'b0;
			state_q <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (room) begin
				valid_s1 <= 1'b0;
			end
			if (direction_we) begin
				direction_q <= direction;
				state_q <= '0;
			end else if (valid_s1 && room) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

	// The second byte of a pair follows right after the first is taken.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last && !out_stall |=> out_valid && run_last)
		else $error("second byte of a pair did not follow");

	// A terminator result is a zero byte and closes its request.
	a_end_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_end |-> out_byte == NUL_BYTE && run_last)
		else $error("string_end on a non-terminator byte");

	// Input back-pressure only comes from a full input register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid)
		else $error("in_stall without a blocked input register");

endmodule
